/* hw/rtl/e2g_pkg.sv */
// Shared types, constants and arithmetic helpers of the ECEF to geodetic converter.
package e2g_pkg;

  localparam int CORDIC_STAGES_DEF = 32;

  localparam logic [32:0] A_RESET = 33'd6378137000;
  localparam logic [31:0] F_RESET = 32'd14400212;

  localparam logic CFG_SEMI_MAJOR = 1'b0;
  localparam logic CFG_FLATTENING = 1'b1;

  localparam logic [63:0] TWO_OVER_PI  = 64'hA2F9836E4E441529;
  localparam logic [63:0] QUARTER_TURN = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_TURN    = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] p11;
    logic [63:0] p10;
    logic [63:0] p01;
    logic [63:0] p00;
  } e2g_pp_t;

  typedef struct packed {
    logic [36:0] z;
    logic        polar;
  } side_a_t;

  typedef struct packed {
    logic [63:0] p16;
    logic [63:0] lon;
    side_a_t     a;
  } side_b_t;

  typedef struct packed {
    logic [63:0] spec;
    logic        bad;
    side_b_t     b;
  } side_d_t;

  typedef struct packed {
    logic [63:0] lat;
    side_b_t     b;
  } side_e_t;

  typedef struct packed {
    logic [63:0] t1;
    logic [63:0] t2;
    side_e_t     e;
  } side_f_t;

  function automatic logic [63:0] abs64(input logic [63:0] v);
    abs64 = v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] neg_if(input logic n, input logic [63:0] v);
    neg_if = n ? 64'd0 - v : v;
  endfunction

  function automatic e2g_pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    e2g_pp_t r;
    r.p00 = a[31:0] * b[31:0];
    r.p01 = a[31:0] * b[63:32];
    r.p10 = a[63:32] * b[31:0];
    r.p11 = a[63:32] * b[63:32];
    pp_mul = r;
  endfunction

  function automatic logic [63:0] pp_sum(input e2g_pp_t pp, input int s);
    logic [127:0] full;
    logic [127:0] sh;
    full = {pp.p11, pp.p00} + {32'd0, pp.p01, 32'd0} + {32'd0, pp.p10, 32'd0};
    sh = full >> s;
    pp_sum = sh[63:0];
  endfunction

  function automatic logic [63:0] wmul_c(input logic [63:0] a, input logic [63:0] b,
                                         input int s);
    logic [127:0] full;
    logic [127:0] sh;
    full = {64'd0, a} * {64'd0, b};
    sh = full >> s;
    wmul_c = sh[63:0];
  endfunction

  function automatic logic [63:0] udiv_c(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    udiv_c = q;
  endfunction

  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] pw;
    logic [63:0] acc;
    logic [63:0] t;
    logic        done;
    if (i == 0) begin
      atan_entry = 64'd1 << 61;
    end else begin
      pw = 64'd1 << (64 - i);
      acc = pw;
      done = 1'b0;
      for (int k = 1; k < 64; k++) begin
        if (!done) begin
          if (2 * i >= 64) pw = 64'd0;
          else pw = pw >> (2 * i);
          t = udiv_c(pw, 64'(2 * k + 1));
          if (t == 64'd0) done = 1'b1;
          else if (k[0] == 1'b1) acc = acc - t;
          else acc = acc + t;
        end
      end
      atan_entry = wmul_c(acc, TWO_OVER_PI, 66);
    end
  endfunction

  function automatic logic [63:0] inv_gain(input int n);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] rem;
    logic [63:0] q;
    x = 64'd1 << 60;
    y = 64'd0;
    for (int i = 0; i < n; i++) begin
      dx = $signed(y) >>> i;
      dy = $signed(x) >>> i;
      if (y[63]) begin
        x = x - dx;
        y = y + dy;
      end else begin
        x = x + dx;
        y = y - dy;
      end
    end
    rem = (64'd1 << 61) - x;
    q = 64'd1;
    for (int k = 0; k < 61; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= x) begin
        rem = rem - x;
        q = q | 64'd1;
      end
    end
    inv_gain = q;
  endfunction

endpackage

/* hw/rtl/e2g_cordic.sv */
// Pipelined circular CORDIC, one stage per iteration, vectoring or rotation mode.
module e2g_cordic import e2g_pkg::*; #(
  parameter int STAGES    = CORDIC_STAGES_DEF,
  parameter int SIDE_W    = 1,
  parameter bit VECTORING = 1'b1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       x_in,
  input  logic [63:0]       y_in,
  input  logic [63:0]       z_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [63:0]       x_out,
  output logic [63:0]       y_out,
  output logic [63:0]       z_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [STAGES:0] v;
  logic [63:0]       xs [0:STAGES];
  logic [63:0]       ys [0:STAGES];
  logic [63:0]       zs [0:STAGES];
  logic [SIDE_W-1:0] ss [0:STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (VECTORING && x_in[63]) begin
        xs[0] <= 64'd0 - x_in;
        ys[0] <= 64'd0 - y_in;
        zs[0] <= HALF_TURN;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= z_in;
      end
      ss[0] <= side_in;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [63:0] Rom = atan_entry(i);
    logic [63:0] dx;
    logic [63:0] dy;
    logic        sub;
    assign dx  = $signed(ys[i]) >>> i;
    assign dy  = $signed(xs[i]) >>> i;
    assign sub = VECTORING ? ys[i][63] : !zs[i][63];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (sub) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - Rom;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + Rom;
        end
        ss[i+1] <= ss[i];
      end
    end
  end

  assign out_valid = v[STAGES];
  assign x_out     = xs[STAGES];
  assign y_out     = ys[STAGES];
  assign z_out     = zs[STAGES];
  assign side_out  = ss[STAGES];

endmodule

/* hw/rtl/ecef_to_geodetic_top.sv */
// Top level of the ECEF to geodetic converter: ellipsoid setup, pipeline and stream ports.
//
// Converts one ECEF position per clock into latitude, longitude and height by
// Bowring's closed form. The datapath is a pipeline of six CORDIC chains of
// CORDIC_STAGES stages each plus seven multiply stage pairs and a few adjust stages,
// and a new word may enter every cycle unless the setup sequencer is busy or a full
// output holds the pipeline. After reset and after every configuration write a
// sequencer derives the ellipsoid constants with a one-bit-per-cycle divider, and
// s_tready is low during that time. An output register and one extra result stage
// keep the input side flowing while a result waits to be taken.
module ecef_to_geodetic_top import e2g_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // x_mm[36:0], y_mm[73:37], z_mm[110:74]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // latitude[31:0], longitude[63:32], height_mm[100:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [32:0]  cfg_data
);

  localparam logic [63:0] InvGain = inv_gain(CORDIC_STAGES);
  localparam logic [63:0] RotX0   = InvGain >> 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_G    = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_SUM1 = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_MUL2 = 3'd5;
  localparam logic [2:0] ST_SUM2 = 3'd6;

  // Ellipsoid setup.
  logic [2:0]  seq_state;
  logic [32:0] semi_a;
  logic [31:0] flat_f;
  logic [31:0] fcl;
  logic [32:0] g;
  logic [63:0] b16, e2, ep2b, e2a;
  e2g_pp_t     ppa, ppb;
  logic [33:0] rem;
  logic [33:0] rem_sh;
  logic [63:0] dvd, quo;
  logic [5:0]  cnt;
  logic [63:0] a16;
  logic [63:0] e2_new;

  assign cfg_ready = 1'b1;
  assign a16       = {15'd0, semi_a, 16'd0};
  assign rem_sh    = {rem[32:0], dvd[63]};
  assign e2_new    = pp_sum(ppb, 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= ST_G;
      semi_a    <= A_RESET;
      flat_f    <= F_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seq_state <= ST_G;
      case (cfg_index)
        CFG_SEMI_MAJOR: semi_a <= cfg_data;
        CFG_FLATTENING: flat_f <= cfg_data[31:0];
        default: ;
      endcase
    end else begin
      case (seq_state)
        ST_G:    seq_state <= ST_MUL1;
        ST_MUL1: seq_state <= ST_SUM1;
        ST_SUM1: seq_state <= ST_DIV;
        ST_DIV:  if (cnt == 6'd0) seq_state <= ST_MUL2;
        ST_MUL2: seq_state <= ST_SUM2;
        ST_SUM2: seq_state <= ST_IDLE;
        default: seq_state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (seq_state)
      ST_G: begin
        fcl <= (flat_f > 32'h8000_0000) ? 32'h8000_0000 : flat_f;
        g   <= 33'h1_0000_0000 - ((flat_f > 32'h8000_0000) ? 33'h0_8000_0000
                                                            : {1'b0, flat_f});
      end
      ST_MUL1: begin
        ppa <= pp_mul({31'd0, semi_a}, {31'd0, g});
        ppb <= pp_mul({32'd0, fcl}, 64'h2_0000_0000 - {32'd0, fcl});
      end
      ST_SUM1: begin
        b16 <= pp_sum(ppa, 16);
        e2  <= e2_new;
        dvd <= {e2_new[31:0], 32'd0};
        rem <= 34'd0;
        quo <= 64'd0;
        cnt <= 6'd63;
      end
      ST_DIV: begin
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (rem_sh >= {1'b0, g}) begin
          rem <= rem_sh - {1'b0, g};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
      end
      ST_MUL2: begin
        ppa <= pp_mul({31'd0, semi_a}, quo);
        ppb <= pp_mul({31'd0, semi_a}, e2);
      end
      ST_SUM2: begin
        ep2b <= pp_sum(ppa, 16);
        e2a  <= pp_sum(ppb, 16);
      end
      default: ;
    endcase
  end

  // Pipeline control.
  logic en, pv, ov;
  logic in_acc;

  assign en       = !pv || !ov || m_tready;
  assign s_tready = en && (seq_state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // Input stage.
  logic        v1;
  logic [36:0] x1, y1, z1;
  side_a_t     sa_in;

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= s_tdata[36:0];
      y1 <= s_tdata[73:37];
      z1 <= s_tdata[110:74];
    end
  end

  assign sa_in.z     = z1;
  assign sa_in.polar = (x1 == 37'd0) && (y1 == 37'd0);

  // Longitude and horizontal magnitude.
  logic        va;
  logic [63:0] xa, za;
  side_a_t     sa;

  e2g_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W($bits(side_a_t)), .VECTORING(1'b1)) u_lon (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .x_in({{11{x1[36]}}, x1, 16'd0}), .y_in({{11{y1[36]}}, y1, 16'd0}), .z_in(64'd0),
    .side_in(sa_in), .out_valid(va), .x_out(xa), .y_out(), .z_out(za), .side_out(sa)
  );

  logic        v2, v3, v4, v5;
  e2g_pp_t     pp2, pp4;
  logic [63:0] lon2, lon3, lon4, lon5, p16_3, p16_4, p16_5, tx5;
  side_a_t     s2, s3, s4, s5;

  always_ff @(posedge clk) begin
    if (en) begin
      pp2   <= pp_mul(xa, InvGain);
      lon2  <= za;
      s2    <= sa;
      p16_3 <= pp_sum(pp2, 62);
      lon3  <= lon2;
      s3    <= s2;
      pp4   <= pp_mul(p16_3, {31'd0, g});
      p16_4 <= p16_3;
      lon4  <= lon3;
      s4    <= s3;
      tx5   <= pp_sum(pp4, 32);
      p16_5 <= p16_4;
      lon5  <= lon4;
      s5    <= s4;
    end
  end

  // Parametric latitude and its sine and cosine.
  side_b_t     sb_in, sb, sc;
  logic        vb, vc;
  logic [63:0] zb, cc, cs;

  assign sb_in.p16 = p16_5;
  assign sb_in.lon = lon5;
  assign sb_in.a   = s5;

  e2g_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W($bits(side_b_t)), .VECTORING(1'b1)) u_theta (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5),
    .x_in(tx5), .y_in({{11{s5.z[36]}}, s5.z, 16'd0}), .z_in(64'd0),
    .side_in(sb_in), .out_valid(vb), .x_out(), .y_out(), .z_out(zb), .side_out(sb)
  );

  e2g_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W($bits(side_b_t)), .VECTORING(1'b0)) u_sct (
    .clk(clk), .rst(rst), .en(en), .in_valid(vb),
    .x_in(RotX0), .y_in(64'd0), .z_in(zb),
    .side_in(sb), .out_valid(vc), .x_out(cc), .y_out(cs), .z_out(), .side_out(sc)
  );

  // Cubes, correction terms, numerator and denominator.
  logic        v6, v7, v8, v9, v10, v11, v12;
  logic [63:0] ms6, mc6, ms7, mc7, sq_s7, sq_c7, cube_s9, cube_c9, ts11, tc11;
  logic [63:0] num12, den12;
  logic        ns6, nc6, ns7, nc7, ns8, nc8, ns10, nc10;
  e2g_pp_t     pps6, ppc6, pps8, ppc8, pps10, ppc10;
  side_b_t     s6, s7, s8, s9, s10, s11, s12;

  always_ff @(posedge clk) begin
    if (en) begin
      ms6     <= abs64(cs);
      mc6     <= abs64(cc);
      ns6     <= cs[63];
      nc6     <= cc[63];
      pps6    <= pp_mul(abs64(cs), abs64(cs));
      ppc6    <= pp_mul(abs64(cc), abs64(cc));
      s6      <= sc;
      sq_s7   <= pp_sum(pps6, 60);
      sq_c7   <= pp_sum(ppc6, 60);
      ms7     <= ms6;
      mc7     <= mc6;
      ns7     <= ns6;
      nc7     <= nc6;
      s7      <= s6;
      pps8    <= pp_mul(sq_s7, ms7);
      ppc8    <= pp_mul(sq_c7, mc7);
      ns8     <= ns7;
      nc8     <= nc7;
      s8      <= s7;
      cube_s9 <= neg_if(ns8, pp_sum(pps8, 60));
      cube_c9 <= neg_if(nc8, pp_sum(ppc8, 60));
      s9      <= s8;
      pps10   <= pp_mul(abs64(cube_s9), ep2b);
      ppc10   <= pp_mul(abs64(cube_c9), e2a);
      ns10    <= cube_s9[63];
      nc10    <= cube_c9[63];
      s10     <= s9;
      ts11    <= neg_if(ns10, pp_sum(pps10, 60));
      tc11    <= neg_if(nc10, pp_sum(ppc10, 60));
      s11     <= s10;
      num12   <= {{11{s11.a.z[36]}}, s11.a.z, 16'd0} + ts11;
      den12   <= s11.p16 - tc11;
      s12     <= s11;
    end
  end

  // Geodetic latitude.
  side_d_t     sd_in, sd;
  logic        vd;
  logic [63:0] zd;

  assign sd_in.spec = (num12 == 64'd0) ? 64'd0
                    : (num12[63] ? 64'd0 - QUARTER_TURN : QUARTER_TURN);
  assign sd_in.bad  = (den12 == 64'd0) || den12[63];
  assign sd_in.b    = s12;

  e2g_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W($bits(side_d_t)), .VECTORING(1'b1)) u_lat (
    .clk(clk), .rst(rst), .en(en), .in_valid(v12),
    .x_in(den12), .y_in(num12), .z_in(64'd0),
    .side_in(sd_in), .out_valid(vd), .x_out(), .y_out(), .z_out(zd), .side_out(sd)
  );

  logic        v13;
  logic [63:0] lat_sel;
  logic [63:0] lat13;
  side_b_t     s13;

  assign lat_sel = sd.bad ? sd.spec : zd;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!lat_sel[63] && lat_sel > QUARTER_TURN) lat13 <= QUARTER_TURN;
      else if (lat_sel[63] && (64'd0 - lat_sel) > QUARTER_TURN)
        lat13 <= 64'd0 - QUARTER_TURN;
      else lat13 <= lat_sel;
      s13 <= sd.b;
    end
  end

  // Height terms.
  side_e_t     se_in, se;
  logic        ve;
  logic [63:0] cl, sl;

  assign se_in.lat = lat13;
  assign se_in.b   = s13;

  e2g_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W($bits(side_e_t)), .VECTORING(1'b0)) u_scl (
    .clk(clk), .rst(rst), .en(en), .in_valid(v13),
    .x_in(RotX0), .y_in(64'd0), .z_in(lat13),
    .side_in(se_in), .out_valid(ve), .x_out(cl), .y_out(sl), .z_out(), .side_out(se)
  );

  logic        v14, v15;
  e2g_pp_t     pp_ac, pp_bs, pp_t1, pp_t2;
  logic        ncl14, nsl14, nzq14;
  logic [63:0] zq_e;
  logic [63:0] ac15, bs15, t1_15, t2_15;
  side_e_t     s14, s15;

  assign zq_e = {{11{se.b.a.z[36]}}, se.b.a.z, 16'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ac <= pp_mul(abs64(cl), a16);
      pp_bs <= pp_mul(abs64(sl), b16);
      pp_t1 <= pp_mul(abs64(cl), se.b.p16);
      pp_t2 <= pp_mul(abs64(sl), abs64(zq_e));
      ncl14 <= cl[63];
      nsl14 <= sl[63];
      nzq14 <= zq_e[63];
      s14   <= se;
      ac15  <= neg_if(ncl14, pp_sum(pp_ac, 60));
      bs15  <= neg_if(nsl14, pp_sum(pp_bs, 60));
      t1_15 <= neg_if(ncl14, pp_sum(pp_t1, 60));
      t2_15 <= neg_if(nzq14, neg_if(nsl14, pp_sum(pp_t2, 60)));
      s15   <= s14;
    end
  end

  side_f_t     sf_in, sf;
  logic        vf;
  logic [63:0] xf;

  assign sf_in.t1 = t1_15;
  assign sf_in.t2 = t2_15;
  assign sf_in.e  = s15;

  e2g_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W($bits(side_f_t)), .VECTORING(1'b1)) u_rad (
    .clk(clk), .rst(rst), .en(en), .in_valid(v15),
    .x_in(ac15), .y_in(bs15), .z_in(64'd0),
    .side_in(sf_in), .out_valid(vf), .x_out(xf), .y_out(), .z_out(), .side_out(sf)
  );

  // Final height, polar case, rounding and saturation.
  logic        v16, v17;
  e2g_pp_t     pp16;
  side_f_t     s16;
  logic [63:0] h17, lat17, lon17;
  logic [63:0] zabs16;
  logic [63:0] hr, hm;
  logic [36:0] h_out;
  logic [63:0] lat_rnd, lon_rnd;
  logic [31:0] lat_out, lon_out;
  logic [31:0] lat_p, lon_p;
  logic [36:0] h_p;

  assign zabs16 = abs64({{27{s16.e.b.a.z[36]}}, s16.e.b.a.z});

  always_ff @(posedge clk) begin
    if (en) begin
      pp16 <= pp_mul(xf, InvGain);
      s16  <= sf;
      if (s16.e.b.a.polar) begin
        h17   <= {zabs16[47:0], 16'd0} - b16;
        lon17 <= 64'd0;
        lat17 <= (s16.e.b.a.z == 37'd0) ? 64'd0
               : (s16.e.b.a.z[36] ? 64'd0 - QUARTER_TURN : QUARTER_TURN);
      end else begin
        h17   <= s16.t1 + s16.t2 - pp_sum(pp16, 62);
        lon17 <= s16.e.b.lon;
        lat17 <= s16.e.lat;
      end
    end
  end

  assign hr = h17 + 64'h8000;
  assign hm = $signed(hr) >>> 16;

  always_comb begin
    if (!hm[63] && hm > 64'h0000_000F_FFFF_FFFF) h_out = 37'h0F_FFFF_FFFF;
    else if (hm[63] && (64'd0 - hm) > 64'h0000_0010_0000_0000) h_out = 37'h10_0000_0000;
    else h_out = hm[36:0];
  end

  assign lat_rnd = lat17 + 64'h8000_0000;
  assign lon_rnd = lon17 + 64'h8000_0000;
  assign lat_out = lat_rnd[63:32];
  assign lon_out = lon_rnd[63:32];

  always_ff @(posedge clk) begin
    if (en) begin
      lat_p <= lat_out;
      lon_p <= lon_out;
      h_p   <= h_out;
    end
    if (!ov || m_tready) begin
      m_tdata <= {3'd0, h_p, lon_p, lat_p};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12} <= '0;
      {v13, v14, v15, v16, v17, pv, ov} <= '0;
    end else begin
      if (en) begin
        v1  <= in_acc;
        v2  <= va;
        v3  <= v2;
        v4  <= v3;
        v5  <= v4;
        v6  <= vc;
        v7  <= v6;
        v8  <= v7;
        v9  <= v8;
        v10 <= v9;
        v11 <= v10;
        v12 <= v11;
        v13 <= vd;
        v14 <= ve;
        v15 <= v14;
        v16 <= vf;
        v17 <= v16;
        pv  <= v17;
      end
      if (!ov || m_tready) begin
        ov <= pv;
      end
    end
  end

  assign m_tvalid = ov;

`ifndef SYNTH
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (seq_state != ST_IDLE) |-> !s_tready)
    else $error("input accepted while ellipsoid constants are being derived");

  a_cfg_restarts_setup: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (seq_state == ST_G))
    else $error("configuration write did not restart the setup sequencer");

  a_result_moves_out: assert property (@(posedge clk) disable iff (rst)
    (pv && !ov) |=> ov)
    else $error("finished result not moved to the output register");

  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sh4000_0000 &&
                  $signed(m_tdata[31:0]) >= -32'sh4000_0000))
    else $error("latitude beyond a quarter turn");
`endif

endmodule

/* bench/tb_ecef_to_geodetic_top.sv */
// Self-checking testbench of the ECEF to geodetic converter with a bit-exact predictor.
`timescale 1ns / 100ps

module tb_ecef_to_geodetic_top;
  import e2g_pkg::*;

  localparam int NSTG = 32;
  localparam int DRAIN_CYCLES = 6 * (NSTG + 1) + 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [31:0] lat;
    logic [31:0] lon;
    logic [36:0] hgt;
  } fix_t;

  typedef struct {
    logic [36:0] x;
    logic [36:0] y;
    logic [36:0] z;
    bit          typed;
    fix_t        want;
  } pos_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = CFG_SEMI_MAJOR;
  logic [32:0]  cfg_data = '0;

  logic [63:0] atan_tab [NSTG];
  logic [63:0] gain_q62;
  logic [32:0] axis_mm = A_RESET;
  logic [31:0] flat_q32 = F_RESET;

  fix_t pending_fix[$];
  int   errors = 0;
  int   sender_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  ecef_to_geodetic_top uut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] mulsh(input logic [63:0] a, input logic [63:0] b,
                                        input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] smul(input logic [63:0] v, input logic [63:0] u,
                                       input int s);
    logic [63:0] r;
    r = mulsh(mag(v), u, s);
    return v[63] ? 64'd0 - r : r;
  endfunction

  function automatic logic [63:0] smul_ss(input logic [63:0] v, input logic [63:0] w,
                                          input int s);
    logic [63:0] r;
    r = smul(v, mag(w), s);
    return w[63] ? 64'd0 - r : r;
  endfunction

  function automatic logic [63:0] cube(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = mag(v);
    r = mulsh(mulsh(m, m, 60), m, 60);
    return v[63] ? 64'd0 - r : r;
  endfunction

  function automatic logic [63:0] arctan(input logic [63:0] x0, input logic [63:0] y0,
                                         output logic [63:0] xo);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] dx;
    logic [63:0] dy;
    x = x0;
    y = y0;
    z = 64'd0;
    if (x[63]) begin
      x = 64'd0 - x;
      y = 64'd0 - y;
      z = HALF_TURN;
    end
    for (int i = 0; i < NSTG; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y[63]) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    xo = x;
    return z;
  endfunction

  function automatic void sincos(input logic [63:0] ang, output logic [63:0] c,
                                 output logic [63:0] s);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] dx;
    logic [63:0] dy;
    x = gain_q62 >> 2;
    y = 64'd0;
    z = ang;
    for (int i = 0; i < NSTG; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (!z[63]) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  task automatic build_tables();
    logic [63:0] pw;
    logic [63:0] acc;
    logic [63:0] t;
    logic [63:0] kq;
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] dummy;
    bit          done;
    atan_tab[0] = 64'd1 << 61;
    for (int i = 1; i < NSTG; i++) begin
      pw = 64'd1 << (64 - i);
      acc = pw;
      done = 1'b0;
      for (int k = 1; k < 64; k++) begin
        if (!done) begin
          pw = (2 * i >= 64) ? 64'd0 : pw >> (2 * i);
          t = pw / (2 * k + 1);
          if (t == 0) done = 1'b1;
          else if (k % 2 == 1) acc = acc - t;
          else acc = acc + t;
        end
      end
      atan_tab[i] = mulsh(acc, TWO_OVER_PI, 66);
    end
    dummy = arctan(64'd1 << 60, 64'd0, kq);
    rem = (64'd1 << 61) - kq;
    q = 64'd1;
    for (int k = 0; k < 61; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= kq) begin
        rem = rem - kq;
        q = q | 64'd1;
      end
    end
    gain_q62 = q;
  endtask

  function automatic fix_t geo_solve(input logic [36:0] xi, input logic [36:0] yi,
                                     input logic [36:0] zi);
    logic [63:0] f, g, b16, xs, ys, zs, zq, lat, lon, h, hm;
    logic [63:0] p16, pm, tx, th, dummy, c, s, e2, r, ep2b, e2a, num, den;
    logic [63:0] cl, sl, ac, acm, bs;
    fix_t res;
    f = {32'd0, flat_q32};
    if (f > (64'd1 << 31)) f = 64'd1 << 31;
    g = (64'd1 << 32) - f;
    b16 = mulsh({31'd0, axis_mm}, g, 16);
    xs = {{27{xi[36]}}, xi};
    ys = {{27{yi[36]}}, yi};
    zs = {{27{zi[36]}}, zi};
    zq = zs << 16;
    if (xs == 0 && ys == 0) begin
      lon = 64'd0;
      lat = (zs == 0) ? 64'd0 : (zs[63] ? 64'd0 - QUARTER_TURN : QUARTER_TURN);
      h = (mag(zs) << 16) - b16;
    end else begin
      lon = arctan(xs << 16, ys << 16, pm);
      p16 = mulsh(pm, gain_q62, 62);
      tx = mulsh(p16, g, 32);
      th = arctan(tx, zq, dummy);
      sincos(th, c, s);
      e2 = mulsh(f, (64'd1 << 33) - f, 32);
      r = (e2 << 32) / g;
      ep2b = mulsh({31'd0, axis_mm}, r, 16);
      e2a = mulsh({31'd0, axis_mm}, e2, 16);
      num = zq + smul(cube(s), ep2b, 60);
      den = p16 - smul(cube(c), e2a, 60);
      if (den == 0 || den[63])
        lat = (num == 0) ? 64'd0 : (num[63] ? 64'd0 - QUARTER_TURN : QUARTER_TURN);
      else
        lat = arctan(den, num, dummy);
      if (!lat[63] && lat > QUARTER_TURN) lat = QUARTER_TURN;
      if (lat[63] && (64'd0 - lat) > QUARTER_TURN) lat = 64'd0 - QUARTER_TURN;
      sincos(lat, cl, sl);
      ac = smul(cl, {31'd0, axis_mm} << 16, 60);
      bs = smul(sl, b16, 60);
      dummy = arctan(ac, bs, acm);
      h = smul(cl, p16, 60) + smul_ss(sl, zq, 60) - mulsh(acm, gain_q62, 62);
    end
    hm = asr(h + (64'd1 << 15), 16);
    if (!hm[63] && hm > (64'd1 << 36) - 1) hm = (64'd1 << 36) - 1;
    if (hm[63] && (64'd0 - hm) > (64'd1 << 36)) hm = 64'd0 - (64'd1 << 36);
    lat = (lat + (64'd1 << 31)) >> 32;
    lon = (lon + (64'd1 << 31)) >> 32;
    res.lat = lat[31:0];
    res.lon = lon[31:0];
    res.hgt = hm[36:0];
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    fix_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_fix.size() == 0) begin
        report("unexpected word", m_tdata[63:0], 64'd0);
      end else begin
        want = pending_fix.pop_front();
        if (m_tdata[31:0] !== want.lat)
          report("latitude", {32'd0, m_tdata[31:0]}, {32'd0, want.lat});
        if (m_tdata[63:32] !== want.lon)
          report("longitude", {32'd0, m_tdata[63:32]}, {32'd0, want.lon});
        if (m_tdata[100:64] !== want.hgt)
          report("height", {27'd0, m_tdata[100:64]}, {27'd0, want.hgt});
      end
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_empty();
    while (pending_fix.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [32:0] value);
    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SEMI_MAJOR) axis_mm = value;
    else flat_q32 = value[31:0];
  endtask

  task automatic send_pos(input logic [36:0] x, input logic [36:0] y, input logic [36:0] z,
                          input bit typed, input fix_t want);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_fix.push_back(typed ? want : geo_solve(x, y, z));
  endtask

  function automatic logic [36:0] rand_coord();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return {{3{v[33]}}, v[33:0]};
      5, 6:          return v[36:0];
      7:             return 37'd0;
      8:             return {{26{v[10]}}, v[10:0]};
      default:       return v[0] ? {1'b1, 36'd0} : {1'b0, {36{1'b1}}};
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [36:0] x;
    logic [36:0] y;
    fix_t none;
    none = '0;
    for (int n = 0; n < count; n++) begin
      x = rand_coord();
      y = rand_coord();
      if ($urandom_range(9) == 0) begin
        x = 37'd0;
        y = 37'd0;
      end
      send_pos(x, y, rand_coord(), 1'b0, none);
    end
    s_tvalid <= 1'b0;
  endtask

  pos_row_t rows [$];
  localparam logic [36:0] CMAX = {1'b0, {36{1'b1}}};
  localparam logic [36:0] CMIN = {1'b1, 36'd0};
  localparam logic [36:0] EARTH = 37'd6378137000;

  initial begin
    logic [63:0] rv;
    build_tables();
    rows = '{
      '{37'd0, 37'd0, 37'd0, 1'b1, '{32'd0, 32'd0, 37'd0 - EARTH}},
      '{37'd0, 37'd0, 37'd7000000000, 1'b1, '{32'h4000_0000, 32'd0, 37'd621863000}},
      '{37'd0, 37'd0, 37'd0 - EARTH, 1'b1, '{32'hC000_0000, 32'd0, 37'd0}},
      '{37'd0, 37'd0, CMAX, 1'b1, '{32'h4000_0000, 32'd0, CMAX - EARTH}},
      '{37'd0, 37'd0, CMIN, 1'b1, '{32'hC000_0000, 32'd0, CMIN - EARTH}},
      '{EARTH, 37'd0, 37'd0, 1'b0, '0},
      '{37'd0 - EARTH, 37'd0, 37'd0, 1'b0, '0},
      '{37'd0, EARTH, 37'd0, 1'b0, '0},
      '{37'd0, 37'd0 - EARTH, 37'd0, 1'b0, '0},
      '{37'd1, 37'd0, 37'd0, 1'b0, '0},
      '{37'd0 - 37'd1, 37'd0, 37'd5, 1'b0, '0},
      '{CMAX, CMAX, CMAX, 1'b0, '0},
      '{CMIN, CMIN, CMIN, 1'b0, '0},
      '{CMIN, 37'd0, 37'd0, 1'b0, '0},
      '{CMAX, CMIN, 37'd0, 1'b0, '0},
      '{CMIN, CMAX, CMIN, 1'b0, '0},
      '{37'd4510731000, 37'd4510731000, 37'd0, 1'b0, '0},
      '{37'd1000, 37'd1000, 37'd6356752314, 1'b0, '0},
      '{37'd3000000000, 37'd0 - 37'd2000000000, 37'd0 - 37'd5000000000, 1'b0, '0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_random(100);

    write_reg(CFG_FLATTENING, 33'd0);
    foreach (rows[i]) send_pos(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
    s_tvalid <= 1'b0;

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_SEMI_MAJOR, {33{1'b1}});
          write_reg(CFG_FLATTENING, 33'h0_8000_0000);
        end
        2: begin
          write_reg(CFG_SEMI_MAJOR, 33'd1);
          write_reg(CFG_FLATTENING, 33'h0_FFFF_FFFF);
        end
        3: begin
          write_reg(CFG_SEMI_MAJOR, A_RESET);
          write_reg(CFG_FLATTENING, {1'b0, F_RESET});
        end
        4: begin
          rv = {$urandom, $urandom};
          write_reg(CFG_SEMI_MAJOR, (rv[32:0] == 0) ? 33'd1 : rv[32:0]);
          write_reg(CFG_FLATTENING, {9'd0, rv[55:32]});
        end
        default: begin
          rv = {$urandom, $urandom};
          write_reg(CFG_SEMI_MAJOR, rv[32:0] | 33'd1);
          write_reg(CFG_FLATTENING, {1'b0, rv[63:32]});
        end
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin sender_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (ph == 3) begin
        sender_idle_pct = 0;
        hold_req = 1'b1;
        send_random(300);
        wait_empty();
        sender_idle_pct = 38;
      end
      send_random(200);
    end

    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
